### design/bspline_weight_generator_core_assert.svh
// ----------------------------------------------------------------------------
// bspline weight generator assertion macros
// Concurrent assertion wrappers for the B-spline weight generator. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_WEIGHT_GENERATOR_CORE_ASSERT_SVH
`define BSPLINE_WEIGHT_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge out of reset
`define BWG_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("bspline weight generator: assertion failed");

// next-cycle implication
`define BWG_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("bspline weight generator: assertion failed");

`else

`define BWG_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons)
`define BWG_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

### design/bswg_pkg.sv
// ----------------------------------------------------------------------------
// bswg_pkg
// Types and constants shared by the B-spline weight generator: fixed-point
// formats, register indexes and the per-stage payload records.
// ----------------------------------------------------------------------------
package bswg_pkg;

	// largest spline order the datapath is sized for
	localparam int MAX_ORDER = 8;
	localparam int FRAC_W    = 30;
	localparam int IDX_W     = 3;
	localparam int SCALE_W   = 24;
	localparam int COORD_W   = 32;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// inverse spacing after reset is 1.0 in Q8.16
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		REG_INV_SPACING_X = 2'd0,
		REG_INV_SPACING_Y = 2'd1,
		REG_INV_SPACING_Z = 2'd2
	} reg_idx_t;

	typedef logic [FRAC_W-1:0] frac_t;   // dr, Q0.30
	typedef logic [30:0]       wgt_t;    // weight, Q1.30 (never above 1.0)
	typedef logic [60:0]       mprod_t;  // dr * weight
	typedef logic [34:0]       coef_t;   // integer-coefficient part of a step
	typedef logic [33:0]       quo_t;    // dividend and quotient of a step
	typedef logic [31:0]       dif_t;    // derivative, Q.30 two's complement
	typedef logic [17:0]       der_t;    // derivative, Q1.16 two's complement
	typedef logic [16:0]       wout_t;   // weight, Q1.16

	localparam wgt_t        ONE_W    = 31'h4000_0000;
	localparam wgt_t        WGT_HALF = 31'd8192;
	localparam logic [31:0] DER_HALF = 32'd8192;
	localparam wout_t       WOUT_ONE = 17'd65536;

	// recursion step, after the multipliers
	typedef struct packed {
		frac_t                         dr;
		logic [1:0]                    axis;
		mprod_t [MAX_ORDER-1:0]        m;
		coef_t  [MAX_ORDER-1:0]        c;
		dif_t   [MAX_ORDER-1:0]        d;
	} mul_t;

	// recursion step, after the sums and derivative rounding
	typedef struct packed {
		frac_t                         dr;
		logic [1:0]                    axis;
		quo_t   [MAX_ORDER-1:0]        y;
		der_t   [MAX_ORDER-1:0]        der;
	} sum_t;

	// recursion step, after the reciprocal multiply
	typedef struct packed {
		frac_t                         dr;
		logic [1:0]                    axis;
		quo_t   [MAX_ORDER-1:0]        y;
		quo_t   [MAX_ORDER-1:0]        q0;
		der_t   [MAX_ORDER-1:0]        der;
	} rcp_t;

	// weight set between recursion steps
	typedef struct packed {
		frac_t                         dr;
		logic [1:0]                    axis;
		wgt_t   [MAX_ORDER-1:0]        w;
		der_t   [MAX_ORDER-1:0]        der;
	} wset_t;

endpackage

### design/bspline_weight_generator_core.sv
// ----------------------------------------------------------------------------
// bspline_weight_generator_core
// Cardinal B-spline interpolation weights and derivatives for one atom
// coordinate on one axis, computed by a Cox-de Boor recursion pipeline.
// ----------------------------------------------------------------------------
// Each accepted item (a Q12.20 coordinate and an axis) is scaled by that
// axis's inverse grid spacing, and its fractional cell offset runs through
// ORDER-2 recursion steps of four register stages each (multiply, sum,
// reciprocal multiply, quotient correction), after two front stages for
// axis select and scaling. A new item may enter every cycle unless the pipe
// is stalled; a charged item then sits in an output register that hands out
// ORDER results, one per cycle while spline_ready is high, so the sustained
// intake of charged items is set by the output port. An uncharged item, or
// one with axis code 3, is taken in but gives no results. The inverse spacing
// registers sit at byte addresses 0, 4 and 8 of the APB port; the user must
// write them only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "bspline_weight_generator_core_assert.svh"

module bspline_weight_generator_core
	import bswg_pkg::*;
#(
	parameter int ORDER = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,

	// atom coordinate items
	input  logic                      atom_valid,
	output logic                      atom_ready,
	input  logic signed [COORD_W-1:0] coordinate,
	input  logic [1:0]                axis,
	input  logic                      has_charge,

	// weight items
	output logic                      spline_valid,
	input  logic                      spline_ready,
	output logic [16:0]               weight,
	output logic signed [17:0]        derivative,
	output logic [IDX_W-1:0]          spline_index,
	output logic [1:0]                axis_out,
	output logic                      last
);

	localparam int NSTEP = ORDER - 2;
	localparam int NST   = 2 + 4 * NSTEP;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER - 1);

	// configuration registers
	logic [SCALE_W-1:0] inv_spacing_x_q;
	logic [SCALE_W-1:0] inv_spacing_y_q;
	logic [SCALE_W-1:0] inv_spacing_z_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	// pipeline control
	logic [NST-1:0] valid_q;
	logic [NST-1:0] vin;
	logic [NST:0]   rdy;

	// front stages
	logic signed [COORD_W-1:0] coord_s1;
	logic [SCALE_W-1:0]        scale_s1;
	logic [1:0]                axis_s1;
	logic [SCALE_W-1:0]        scale_sel;
	logic signed [56:0]        scaled;
	frac_t                     dr_s2;
	logic [1:0]                axis_s2;
	wset_t                     init_set;
	wset_t                     step_out [NSTEP];

	// output register
	logic           obuf_valid_q;
	logic [IDX_W-1:0] idx_q;
	wout_t          wbuf_q [MAX_ORDER];
	der_t           dbuf_q [MAX_ORDER];
	logic [1:0]     axis_q;
	wout_t          wround [MAX_ORDER];
	wgt_t           wsum [MAX_ORDER];

	// register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_spacing_x_q <= SCALE_RST;
			inv_spacing_y_q <= SCALE_RST;
			inv_spacing_z_q <= SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INV_SPACING_X: inv_spacing_x_q <= pwdata[SCALE_W-1:0];
				REG_INV_SPACING_Y: inv_spacing_y_q <= pwdata[SCALE_W-1:0];
				REG_INV_SPACING_Z: inv_spacing_z_q <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INV_SPACING_X: prdata = DATA_W'(inv_spacing_x_q);
			REG_INV_SPACING_Y: prdata = DATA_W'(inv_spacing_y_q);
			REG_INV_SPACING_Z: prdata = DATA_W'(inv_spacing_z_q);
			default:           prdata = '0;
		endcase
	end

	// ready chain: a stage takes new data when empty or when it moves on
	always_comb begin
		rdy[NST] = !obuf_valid_q || (spline_ready && last);
		for (int i = NST - 1; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
	end

	assign atom_ready = rdy[0];
	assign vin = {valid_q[NST-2:0], atom_valid && has_charge && (axis <= AXIS_Z)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (rdy[i]) valid_q[i] <= vin[i];
			end
		end
	end

	// axis select
	always_comb begin
		unique case (axis)
			AXIS_X:  scale_sel = inv_spacing_x_q;
			AXIS_Y:  scale_sel = inv_spacing_y_q;
			AXIS_Z:  scale_sel = inv_spacing_z_q;
			default: scale_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			coord_s1 <= coordinate;
			scale_s1 <= scale_sel;
			axis_s1  <= axis;
		end
	end

	// scale and keep the fraction, truncated to Q0.30
	assign scaled = $signed(coord_s1) * $signed({1'b0, scale_s1});

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dr_s2   <= scaled[35:6];
			axis_s2 <= axis_s1;
		end
	end

	// order-2 weights
	always_comb begin
		init_set      = '0;
		init_set.dr   = dr_s2;
		init_set.axis = axis_s2;
		init_set.w[0] = ONE_W - wgt_t'(dr_s2);
		init_set.w[1] = wgt_t'(dr_s2);
	end

	// one recursion step per generate iteration, order k-1 to order k
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int K    = j + 3;
		localparam int KM1  = j + 2;
		localparam int BASE = 2 + 4 * j;
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / KM1);
		localparam logic [65:0] HALF  = 66'(KM1) << 29;

		wset_t step_in;
		mul_t  mul_d;
		mul_t  mul_s3;
		sum_t  sum_d;
		sum_t  sum_s4;
		rcp_t  rcp_d;
		rcp_t  rcp_s5;
		wset_t wset_d;
		wset_t wset_s6;

		if (j == 0) begin : g_head
			assign step_in = init_set;
		end else begin : g_chain
			assign step_in = step_out[j-1];
		end

		// dr times each weight, integer coefficient terms, derivative differences
		always_comb begin
			wgt_t prev;
			mul_d      = '0;
			mul_d.dr   = step_in.dr;
			mul_d.axis = step_in.axis;
			for (int i = 0; i < MAX_ORDER; i++) begin
				prev = '0;
				if (i > 0) prev = step_in.w[i-1];
				if (i < K - 1) mul_d.m[i] = step_in.dr * step_in.w[i];
				if (i < K) begin
					mul_d.c[i] = coef_t'(K - 1 - i) * coef_t'(prev)
						+ coef_t'(i + 1) * coef_t'(step_in.w[i]);
					mul_d.d[i] = dif_t'(prev) - dif_t'(step_in.w[i]);
				end
			end
		end

		// full numerator with rounding half, drop the 30 fraction bits;
		// derivatives round half away from zero to Q1.16
		always_comb begin
			logic [65:0] num;
			mprod_t      mlo;
			logic [31:0] mag;
			logic [31:0] rsum;
			dif_t        dv;
			sum_d      = '0;
			sum_d.dr   = mul_s3.dr;
			sum_d.axis = mul_s3.axis;
			for (int i = 0; i < MAX_ORDER; i++) begin
				mlo  = '0;
				num  = '0;
				mag  = '0;
				rsum = '0;
				dv   = '0;
				if (i < K) begin
					if (i > 0) mlo = mul_s3.m[i-1];
					num = {1'b0, mul_s3.c[i], 30'd0} + 66'(mlo) - 66'(mul_s3.m[i]) + HALF;
					sum_d.y[i] = num[63:30];
					dv   = mul_s3.d[i];
					mag  = dv[31] ? (32'd0 - dv) : dv;
					rsum = mag + DER_HALF;
					sum_d.der[i] = dv[31] ? (18'd0 - rsum[31:14]) : rsum[31:14];
				end
			end
		end

		// quotient estimate by reciprocal, at most two below the true one
		always_comb begin
			logic [65:0] prod;
			rcp_d      = '0;
			rcp_d.dr   = sum_s4.dr;
			rcp_d.axis = sum_s4.axis;
			rcp_d.y    = sum_s4.y;
			rcp_d.der  = sum_s4.der;
			for (int i = 0; i < MAX_ORDER; i++) begin
				prod = '0;
				if (i < K) begin
					prod = sum_s4.y[i] * RECIP;
					rcp_d.q0[i] = prod[65:32];
				end
			end
		end

		// remainder fits five bits, so the correction looks at the low bits only
		always_comb begin
			logic [4:0] qm;
			logic [4:0] rem;
			logic [1:0] cnt;
			wset_d      = '0;
			wset_d.dr   = rcp_s5.dr;
			wset_d.axis = rcp_s5.axis;
			wset_d.der  = rcp_s5.der;
			for (int i = 0; i < MAX_ORDER; i++) begin
				qm  = '0;
				rem = '0;
				cnt = '0;
				if (i < K) begin
					qm  = 5'(rcp_s5.q0[i][4:0] * KM1);
					rem = rcp_s5.y[i][4:0] - qm;
					cnt = 2'(rem >= 5'(KM1)) + 2'(rem >= 5'(2 * KM1))
						+ 2'(rem >= 5'(3 * KM1));
					wset_d.w[i] = wgt_t'(rcp_s5.q0[i] + 34'(cnt));
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[BASE])     mul_s3  <= mul_d;
			if (rdy[BASE + 1]) sum_s4  <= sum_d;
			if (rdy[BASE + 2]) rcp_s5  <= rcp_d;
			if (rdy[BASE + 3]) wset_s6 <= wset_d;
		end

		assign step_out[j] = wset_s6;
	end

	// final weights round half up to Q1.16
	always_comb begin
		for (int i = 0; i < MAX_ORDER; i++) begin
			wsum[i]   = step_out[NSTEP-1].w[i] + WGT_HALF;
			wround[i] = wsum[i][30:14];
		end
	end

	// output register, one result per cycle in index order while spline_ready is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_valid_q <= 1'b0;
			idx_q        <= '0;
		end else if (rdy[NST]) begin
			obuf_valid_q <= valid_q[NST-1];
			idx_q        <= '0;
		end else if (spline_valid && spline_ready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST]) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				wbuf_q[i] <= wround[i];
				dbuf_q[i] <= step_out[NSTEP-1].der[i];
			end
			axis_q <= step_out[NSTEP-1].axis;
		end
	end

	assign spline_valid = obuf_valid_q;
	assign weight       = wbuf_q[idx_q];
	assign derivative   = dbuf_q[idx_q];
	assign spline_index = idx_q;
	assign axis_out     = axis_q;
	assign last         = (idx_q == LAST_IDX);

	// checks
	`BWG_ASSERT_IMP(a_index_range, clk, arst_n, spline_valid, spline_index <= LAST_IDX)
	`BWG_ASSERT_NXT(a_index_steps, clk, arst_n, spline_valid && spline_ready && !last, spline_valid && (spline_index == $past(spline_index) + 3'd1))
	`BWG_ASSERT_IMP(a_weight_range, clk, arst_n, spline_valid, weight <= WOUT_ONE)
	`BWG_ASSERT_IMP(a_deriv_range, clk, arst_n, spline_valid, ($signed(derivative) >= -18'sd65536) && ($signed(derivative) <= 18'sd65536))
	`BWG_ASSERT_IMP(a_empty_ready, clk, arst_n, valid_q == '0, atom_ready)

endmodule

### tb/bspline_weight_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bspline_weight_checker
// Watches the configuration port and both item channels of the B-spline
// weight generator. It keeps its own copy of the inverse spacings, works out
// the ORDER weights and derivatives of every charged x, y or z atom on entry,
// and compares each weight item that leaves the block with the oldest one owed.
// ----------------------------------------------------------------------------
module bspline_weight_checker
	import bswg_pkg::*;
#(
	parameter int ORDER = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,

	// atom coordinate items
	input  logic                 atom_valid,
	input  logic                 atom_ready,
	input  logic [COORD_W-1:0]   coordinate,
	input  logic [1:0]           axis,
	input  logic                 has_charge,

	// weight items
	input  logic                 spline_valid,
	input  logic                 spline_ready,
	input  logic [16:0]          weight,
	input  logic [17:0]          derivative,
	input  logic [IDX_W-1:0]     spline_index,
	input  logic [1:0]           axis_out,
	input  logic                 last,

	output int                   errors,
	output int                   outstanding
);

	typedef bit [63:0] acc_t;
	typedef acc_t acc_set_t [MAX_ORDER];

	typedef struct packed {
		logic [16:0]      weight;
		logic [17:0]      derivative;
		logic [IDX_W-1:0] index;
		logic [1:0]       axis;
		logic             last;
	} spline_item_t;

	localparam acc_t UNIT = acc_t'(1) << FRAC_W;

	logic [SCALE_W-1:0] inv_spacing [3];
	spline_item_t       pending_weights [$];
	spline_item_t       want;

	// divide by (k-1) * 2^30, rounded half up
	function automatic acc_t div_round(acc_t num, int unsigned km1);
		acc_t den;
		den = acc_t'(km1) << FRAC_W;
		return (num + (den >> 1)) / den;
	endfunction

	// one Cox-de Boor step from order k-1 to order k, highest index first
	function automatic acc_set_t cox_de_boor(acc_set_t w, int unsigned k, acc_t dr);
		acc_set_t    r;
		int unsigned l;
		acc_t        a;
		acc_t        b;
		r = w;
		r[k-1] = div_round(dr * r[k-2], k - 1);
		for (l = 1; l < k - 1; l++) begin
			a = dr + (acc_t'(l) << FRAC_W);
			b = (acc_t'(k - l) << FRAC_W) - dr;
			r[k-l-1] = div_round(a * r[k-l-2] + b * r[k-l-1], k - 1);
		end
		r[0] = div_round((UNIT - dr) * r[0], k - 1);
		return r;
	endfunction

	// weights and derivatives owed for one charged atom
	task automatic predict_spline(logic [COORD_W-1:0] coord, logic [1:0] ax);
		acc_t               prod;
		acc_t               dr;
		acc_t               mag;
		acc_set_t           w;
		bit signed [63:0]   d [MAX_ORDER];
		spline_item_t       e;
		int unsigned        k;
		prod = {{32{coord[COORD_W-1]}}, coord} * acc_t'(inv_spacing[ax]);
		// floor fraction is the low 36 bits, truncated to 30
		dr = acc_t'(prod[35:6]);
		foreach (w[i])
			w[i] = '0;
		w[1] = dr;
		w[0] = UNIT - dr;
		for (k = 3; k < ORDER; k++)
			w = cox_de_boor(w, k, dr);
		// derivatives from the order ORDER-1 set
		d[0] = -$signed(w[0]);
		for (k = 1; k < ORDER; k++)
			d[k] = $signed(w[k-1]) - $signed(w[k]);
		w = cox_de_boor(w, ORDER, dr);
		for (k = 0; k < ORDER; k++) begin
			e.weight = 17'((w[k] + (acc_t'(1) << 13)) >> 14);
			mag = d[k] < 0 ? acc_t'(-d[k]) : acc_t'(d[k]);
			mag = (mag + (acc_t'(1) << 13)) >> 14;
			e.derivative = 18'(d[k] < 0 ? -mag : mag);
			e.index = IDX_W'(k);
			e.axis = ax;
			e.last = (k == ORDER - 1);
			pending_weights.push_back(e);
		end
	endtask

	task automatic compare_field(string field, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
			errors++;
		end
	endtask

	// all channel activity is sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_spacing[REG_INV_SPACING_X] = SCALE_RST;
			inv_spacing[REG_INV_SPACING_Y] = SCALE_RST;
			inv_spacing[REG_INV_SPACING_Z] = SCALE_RST;
			pending_weights.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready &&
				paddr[ADDR_W-1:2] <= REG_INV_SPACING_Z)
				inv_spacing[paddr[ADDR_W-1:2]] = pwdata[SCALE_W-1:0];
			// weight items against the oldest owed
			if (spline_valid && spline_ready) begin
				if (pending_weights.size() == 0) begin
					$display("%0t: unexpected weight item, expected none actual weight %0d",
						$time, weight);
					errors++;
				end else begin
					want = pending_weights.pop_front();
					compare_field("weight", want.weight, weight);
					compare_field("derivative", $signed(want.derivative), $signed(derivative));
					compare_field("spline_index", want.index, spline_index);
					compare_field("axis_out", want.axis, axis_out);
					compare_field("last", want.last, last);
				end
			end
			// uncharged atoms and the unused axis code give nothing
			if (atom_valid && atom_ready && has_charge && axis <= AXIS_Z)
				predict_spline(coordinate, axis);
		end
		outstanding = pending_weights.size();
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the B-spline weight generator: a directed set of
// edge coordinates and axis codes, then phases of random atoms under changing
// inverse spacings and idle patterns. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb
	import bswg_pkg::*;
();

	localparam int ORDER       = 4;
	localparam int DRAIN       = 3 + 4 * (ORDER - 2) + 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ATOMS = 60;
	localparam logic [1:0] AXIS_UNUSED = 2'd3;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      atom_valid = 1'b0;
	logic                      atom_ready;
	logic signed [COORD_W-1:0] coordinate = '0;
	logic [1:0]                axis = AXIS_X;
	logic                      has_charge = 1'b0;
	logic                      spline_valid;
	logic                      spline_ready = 1'b0;
	logic [16:0]               weight;
	logic signed [17:0]        derivative;
	logic [IDX_W-1:0]          spline_index;
	logic [1:0]                axis_out;
	logic                      last;

	int errors;
	int outstanding;
	int cycles = 0;
	int sender_idle = 0;
	int recv_stall = 0;
	int sender_idle_pct [4] = '{0, 87, 0, 36};
	int recv_stall_pct  [4] = '{0, 0, 87, 36};

	always #5 clk = ~clk;

	bspline_weight_generator_core #(.ORDER(ORDER)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.atom_valid(atom_valid), .atom_ready(atom_ready), .coordinate(coordinate),
		.axis(axis), .has_charge(has_charge),
		.spline_valid(spline_valid), .spline_ready(spline_ready), .weight(weight),
		.derivative(derivative), .spline_index(spline_index), .axis_out(axis_out),
		.last(last)
	);

	bspline_weight_checker #(.ORDER(ORDER)) u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.atom_valid(atom_valid), .atom_ready(atom_ready), .coordinate(coordinate),
		.axis(axis), .has_charge(has_charge),
		.spline_valid(spline_valid), .spline_ready(spline_ready), .weight(weight),
		.derivative(derivative), .spline_index(spline_index), .axis_out(axis_out),
		.last(last),
		.errors(errors), .outstanding(outstanding)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		spline_ready <= ($urandom_range(99) >= recv_stall);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// setup and access phases, then a spare wait so psel never toggles twice in a step
	task automatic write_spacing(reg_idx_t idx, logic [SCALE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// one atom item, with random idle cycles ahead of it
	task automatic send_atom(logic [COORD_W-1:0] c, logic [1:0] ax, logic charged);
		while ($urandom_range(99) < sender_idle) begin
			atom_valid <= 1'b0;
			@(negedge clk);
		end
		atom_valid <= 1'b1;
		coordinate <= c;
		axis <= ax;
		has_charge <= charged;
		@(posedge clk);
		while (!atom_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// block idle: nothing owed and the pipe flushed
	task automatic settle();
		atom_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic [SCALE_W-1:0] pick_spacing();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return SCALE_RST;
			4:       return SCALE_W'($urandom_range(1, 1 << 18));
			default: return SCALE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [COORD_W-1:0] c;
		logic [1:0]         ax;
		logic               charged;
		int                 sent;
		int                 phase;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: unit spacing on x, zero on y, largest on z
		write_spacing(REG_INV_SPACING_X, SCALE_RST);
		write_spacing(REG_INV_SPACING_Y, '0);
		write_spacing(REG_INV_SPACING_Z, '1);
		send_atom(32'h0000_0000, AXIS_X, 1'b1);
		send_atom(32'h7FFF_FFFF, AXIS_X, 1'b1);
		send_atom(32'h8000_0000, AXIS_X, 1'b1);
		send_atom(32'hFFFF_FFFF, AXIS_X, 1'b1);
		send_atom(32'h0000_0001, AXIS_X, 1'b1);
		send_atom(32'h0008_0000, AXIS_X, 1'b1);
		send_atom(32'hFFF8_0000, AXIS_X, 1'b1);
		send_atom(32'h000F_FFFF, AXIS_X, 1'b1);
		send_atom(32'h000C_0000, AXIS_Y, 1'b1);
		send_atom(32'h7FFF_FFFF, AXIS_Y, 1'b1);
		send_atom(32'h7FFF_FFFF, AXIS_Z, 1'b1);
		send_atom(32'h8000_0000, AXIS_Z, 1'b1);
		send_atom(32'h0001_2345, AXIS_Z, 1'b1);
		send_atom(32'h0008_0000, AXIS_X, 1'b0);
		send_atom(32'h0008_0000, AXIS_UNUSED, 1'b1);
		send_atom(32'hFFFF_FFFF, AXIS_UNUSED, 1'b0);
		send_atom(32'h0004_0000, AXIS_X, 1'b1);

		// random phases, each with new spacings and its own idle pattern
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			if (phase == 0) begin
				write_spacing(REG_INV_SPACING_X, '1);
				write_spacing(REG_INV_SPACING_Y, SCALE_W'(1));
				write_spacing(REG_INV_SPACING_Z, '0);
			end else begin
				write_spacing(REG_INV_SPACING_X, pick_spacing());
				write_spacing(REG_INV_SPACING_Y, pick_spacing());
				write_spacing(REG_INV_SPACING_Z, pick_spacing());
			end
			sender_idle = sender_idle_pct[phase % 4];
			recv_stall = recv_stall_pct[phase % 4];
			sent = 0;
			while (sent < PHASE_ATOMS) begin
				case ($urandom_range(2))
					0: c = $urandom;
					// within a few length units of the origin, either side
					1: c = COORD_W'($urandom_range(0, 32'h7F_FFFF)) - 32'h40_0000;
					// on or just around a whole length unit
					default: c = ($urandom & 32'hFFF0_0000) + COORD_W'($urandom_range(0, 3))
						- COORD_W'($urandom_range(0, 3));
				endcase
				ax = ($urandom_range(99) < 6) ? AXIS_UNUSED : 2'($urandom_range(AXIS_Z));
				charged = ($urandom_range(99) >= 8);
				send_atom(c, ax, charged);
				sent++;
			end
		end

		settle();
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
